@@ src/assert_macros.svh @@
// Assertion macros used by the checker file.
// No dependencies; each macro expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BCC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bcc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define BCC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bcc assertion failed");

`endif

@@ src/bcc_pkg.sv @@
// Types and constants of the block claim checker.
// No dependencies; used by the classify stage, the top level and the checker.
package bcc_pkg;

  localparam int unsigned BLK_W  = 32;
  localparam int unsigned CNT_W  = 18;
  localparam int unsigned CFG_IW = 2;
  localparam int unsigned CFG_DW = 32;
  localparam int unsigned TOT_W  = 17;

  // Claimed map is stored as rows of bits.
  localparam int unsigned ROW_W  = 8;
  localparam int unsigned ROW_BW = $clog2(ROW_W);

  localparam int unsigned BLK_BYTES = 1024;
  localparam logic [CNT_W-1:0] SECTORS_PER_BLOCK = CNT_W'(BLK_BYTES >> 9);
  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  localparam logic [CFG_IW-1:0] CFG_FIRST_DATA = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_TOTAL      = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_REPAIR     = 2'd2;

  typedef enum logic [1:0] {
    ST_NULL    = 2'd0,
    ST_CLAIMED = 2'd1,
    ST_RANGE   = 2'd2,
    ST_DUP     = 2'd3
  } status_t;

  typedef struct packed {
    logic [BLK_W-1:0] block_number;
    logic             start_of_owner;
    logic             preset;
  } in_t;

  typedef struct packed {
    status_t          status;
    logic [BLK_W-1:0] pointer_after;
    logic [CNT_W-1:0] sector_total;
  } out_t;

  // Decision of the classify stage: the result item and the row write-back.
  typedef struct packed {
    out_t             res;
    logic             wr_en;
    logic [ROW_W-1:0] wr_row;
  } cls_t;

endpackage

@@ src/bcc_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies; read returns the contents before a same-edge write.
module bcc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/bcc_classify.sv @@
// Classify one pointer against its map row and the current sector count.
// Depends on bcc_pkg for the item, result and decision types.
module bcc_classify #(
  parameter int unsigned NUM_BLOCKS = 65536
) (
  input  bcc_pkg::in_t                   item,
  input  logic [bcc_pkg::ROW_W-1:0]      row_bits,
  input  logic                           lowest_data,
  input  logic [bcc_pkg::BLK_W-1:0]      limit,
  input  logic                           repair_enable,
  input  logic [bcc_pkg::CNT_W-1:0]      count,
  output bcc_pkg::cls_t                  cls
);
  import bcc_pkg::*;

  logic [BLK_W-1:0]  blk;
  logic [ROW_BW-1:0] bit_sel;
  logic [ROW_W-1:0]  mask;
  logic              in_store;
  logic [CNT_W-1:0]  base;

  assign blk      = item.block_number;
  assign bit_sel  = blk[ROW_BW-1:0];
  assign mask     = ROW_W'(1) << bit_sel;
  assign in_store = blk < BLK_W'(NUM_BLOCKS);
  assign base     = item.start_of_owner ? '0 : count;

  always_comb begin
    cls.res.status        = ST_NULL;
    cls.res.pointer_after = blk;
    cls.res.sector_total  = base;
    cls.wr_en             = 1'b0;
    cls.wr_row            = row_bits | mask;
    if (item.preset) begin
      // metadata: mark if inside the map, without limit or duplicate checks, never repair
      if (in_store) begin
        cls.res.status = ST_CLAIMED;
        cls.wr_en      = 1'b1;
      end else begin
        cls.res.status = ST_RANGE;
      end
    end else if (blk == '0) begin
      cls.res.status = ST_NULL;
    end else if ((blk < BLK_W'(lowest_data)) || (blk >= limit)) begin
      cls.res.status = ST_RANGE;
      if (repair_enable) begin
        cls.res.pointer_after = '0;
      end
    end else if (row_bits[bit_sel]) begin
      cls.res.status = ST_DUP;
      if (repair_enable) begin
        cls.res.pointer_after = '0;
      end
    end else begin
      cls.res.status = ST_CLAIMED;
      cls.wr_en      = 1'b1;
      if (base > COUNT_MAX - SECTORS_PER_BLOCK) begin
        cls.res.sector_total = COUNT_MAX;
      end else begin
        cls.res.sector_total = base + SECTORS_PER_BLOCK;
      end
    end
  end

endmodule

@@ src/block_claim_checker.sv @@
// Block claim checker: test-and-set of block pointers against a claimed map.
// Path: an accepted item is held in the classify stage, then its result is
// registered in the output register, from which the consumer takes it.
// Throughput: one item per cycle while the output is taken; the map row is read on accept and written
// back as the item leaves the classify stage, with a one-entry forward.
// Reset: synchronous, active low; then a clearing pass over every map row
// zeroes the map while in_ready stays low.
module block_claim_checker #(
  parameter int unsigned NUM_BLOCKS = 65536
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  bcc_pkg::in_t                 in_payload,
  output logic                         out_valid,
  input  logic                         out_ready,
  output bcc_pkg::out_t                out_payload,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [bcc_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [bcc_pkg::CFG_DW-1:0]   cfg_data
);
  import bcc_pkg::*;

  localparam int unsigned ROWS   = (NUM_BLOCKS + ROW_W - 1) / ROW_W;
  localparam int unsigned ROW_AW = $clog2(ROWS);

  // Configuration registers
  logic             first_data_r;
  logic [TOT_W-1:0] total_blocks_r;
  logic             repair_r;

  // Clearing pass
  logic              clr_active_r;
  logic [ROW_AW-1:0] clr_addr_r;

  // Classify stage
  logic              s1_valid_r;
  in_t               s1_item_r;
  logic              fwd_hit_r;
  logic [ROW_W-1:0]  fwd_row_r;

  // Output register and owner sector count
  logic              out_valid_r;
  out_t              out_payload_r;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;

  logic              in_accept;
  logic              s1_adv;
  logic              s1_wr;
  logic [ROW_AW-1:0] s1_row;
  logic [ROW_W-1:0]  s1_bits;
  logic [BLK_W-1:0]  limit;
  cls_t              cls;

  logic              ram_we;
  logic [ROW_AW-1:0] ram_waddr;
  logic [ROW_W-1:0]  ram_wdata;
  logic [ROW_AW-1:0] ram_raddr;
  logic [ROW_W-1:0]  ram_rdata;

  // Configuration is always taken; writes beyond the list are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_data_r   <= 1'b1;
      total_blocks_r <= TOT_W'(65536);
      repair_r       <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_FIRST_DATA: first_data_r   <= cfg_data[0];
        CFG_TOTAL:      total_blocks_r <= cfg_data[TOT_W-1:0];
        CFG_REPAIR:     repair_r       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Effective block count: never past the end of the map.
  assign limit = (BLK_W'(total_blocks_r) > BLK_W'(NUM_BLOCKS)) ?
                 BLK_W'(NUM_BLOCKS) : BLK_W'(total_blocks_r);

  // Handshake: the classify stage advances when the output register frees up,
  // and a new item enters when the stage is empty or as the previous one leaves, but not while clearing.
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !clr_active_r && (!s1_valid_r || s1_adv);
  assign in_accept = in_valid && in_ready;

  // Sweep the map to zero after reset, one row a cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else if (clr_active_r) begin
      clr_addr_r <= clr_addr_r + ROW_AW'(1);
      if (clr_addr_r == ROW_AW'(ROWS - 1)) begin
        clr_active_r <= 1'b0;
      end
    end
  end

  // Map port arbitration: clearing pass owns the write port while active.
  assign s1_row    = s1_item_r.block_number[ROW_BW +: ROW_AW];
  assign s1_wr     = s1_adv && cls.wr_en;
  assign ram_we    = clr_active_r || s1_wr;
  assign ram_waddr = clr_active_r ? clr_addr_r : s1_row;
  assign ram_wdata = clr_active_r ? '0 : cls.wr_row;
  assign ram_raddr = in_payload.block_number[ROW_BW +: ROW_AW];

  bcc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (ROWS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_accept),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Load the classify stage. A write to the same row on the accept edge
  // is missed by the read, so capture it for forwarding.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_hit_r  <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_r <= 1'b1;
        fwd_hit_r  <= s1_wr && (s1_row == ram_raddr);
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item_r <= in_payload;
      fwd_row_r <= cls.wr_row;
    end
  end

  assign s1_bits = fwd_hit_r ? fwd_row_r : ram_rdata;

  bcc_classify #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_classify (
    .item          (s1_item_r),
    .row_bits      (s1_bits),
    .lowest_data   (first_data_r),
    .limit         (limit),
    .repair_enable (repair_r),
    .count         (count_r),
    .cls           (cls)
  );

  // Commit the sector count as the item leaves the classify stage.
  assign count_nxt = s1_adv ? cls.res.sector_total : count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hold the result until the consumer takes it.
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_payload_r <= cls.res;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_payload = out_payload_r;

endmodule

@@ src/bcc_checker.sv @@
// Port-level checks of the block claim checker, bound to the top level.
// Depends on bcc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bcc_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input bcc_pkg::in_t               in_payload,
  input logic                       out_valid,
  input logic                       out_ready,
  input bcc_pkg::out_t              out_payload,
  input logic                       cfg_valid,
  input logic                       cfg_ready,
  input logic [bcc_pkg::CFG_IW-1:0] cfg_index,
  input logic [bcc_pkg::CFG_DW-1:0] cfg_data
);
  import bcc_pkg::*;

  logic unused_ok;
  assign unused_ok = in_valid ^ (|in_payload) ^ cfg_valid ^ cfg_ready ^ (|cfg_index) ^
                     (|cfg_data);

  // Stalled result holds.
  `BCC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_payload))
  // Map is being cleared right after reset: no item taken.
  `BCC_ASSERT_NOW(a_clear_blocks, $past(!rst_n), !in_ready)
  // Null pointer always comes back as zero.
  `BCC_ASSERT_NOW(a_null_zero, out_valid && out_payload.status == ST_NULL,
                  out_payload.pointer_after == '0)
  // Sector totals grow by whole blocks until saturation.
  `BCC_ASSERT_NOW(a_count_even, out_valid && out_payload.sector_total != COUNT_MAX,
                  !out_payload.sector_total[0])

endmodule

bind block_claim_checker bcc_checker u_bcc_checker (.*);
